/* hdl/uf_pkg.sv */
// ----------------------------------------------------------------------------
// uf_pkg
// Shared field widths, operation codes and the result type of the
// disjoint-set engine.
// ----------------------------------------------------------------------------
package uf_pkg;

	localparam int OP_W        = 2;
	localparam int ELEM_W      = 10;
	localparam int COUNT_W     = 11;
	localparam int ELEM_SPAN   = 2 ** ELEM_W;        // addressable elements
	localparam int COUNT_MAX   = 2 ** COUNT_W - 1;   // largest value of a count field
	localparam int COUNT_RESET = 1024;               // element_count after reset

	localparam logic [OP_W-1:0] OP_FIND  = 2'd0;
	localparam logic [OP_W-1:0] OP_SAME  = 2'd1;
	localparam logic [OP_W-1:0] OP_SIZE  = 2'd2;
	localparam logic [OP_W-1:0] OP_MERGE = 2'd3;

	typedef struct packed {
		logic [ELEM_W-1:0]  root;
		logic               flag;
		logic [COUNT_W-1:0] set_size;
		logic [COUNT_W-1:0] components;
		logic               index_error;
	} uf_result_t;

	// same-set test and merge use the second element
	function automatic logic needs_second(input logic [OP_W-1:0] op);
		return op inside {OP_SAME, OP_MERGE};
	endfunction

endpackage

/* hdl/uf_if.sv */
// ----------------------------------------------------------------------------
// uf_req_if / uf_rsp_if
// Valid/ready channels for operation requests and results.
// ----------------------------------------------------------------------------
interface uf_req_if import uf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [ELEM_W-1:0] first_element;
	logic [ELEM_W-1:0] second_element;

	modport source (output valid, output operation, output first_element,
		output second_element, input ready);
	modport sink (input valid, input operation, input first_element,
		input second_element, output ready);
endinterface

interface uf_rsp_if import uf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ELEM_W-1:0]  root;
	logic               flag;
	logic [COUNT_W-1:0] set_size;
	logic [COUNT_W-1:0] components;
	logic               index_error;

	modport source (output valid, output root, output flag, output set_size,
		output components, output index_error, input ready);
	modport sink (input valid, input root, input flag, input set_size,
		input components, input index_error, output ready);
endinterface

/* hdl/uf_core.sv */
// ----------------------------------------------------------------------------
// uf_core
// Sequencer plus parent and size memories. Walks parent chains, compresses
// them, merges by size and runs the init sweep.
// ----------------------------------------------------------------------------
module uf_core import uf_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_data,
	uf_req_if.sink             req,
	output uf_result_t         res,
	output logic               res_valid,
	input  logic               res_ready
);

	localparam int DEPTH = (MAX_ELEMENTS > ELEM_SPAN) ? ELEM_SPAN : MAX_ELEMENTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = $clog2(DEPTH + 1);
	localparam int CAP   = (DEPTH > COUNT_MAX) ? COUNT_MAX : DEPTH;
	localparam int RST_COUNT = (COUNT_RESET > CAP) ? CAP : COUNT_RESET;

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_WALK = 3'd2;
	localparam logic [2:0] ST_COMP = 3'd3;
	localparam logic [2:0] ST_SZ1  = 3'd4;
	localparam logic [2:0] ST_SZ2  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]         state_q;
	logic [AW:0]        sweep_q;
	logic [AW:0]        sweep_end;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] comp_q;
	logic [COUNT_W-1:0] cfg_sat;
	logic [OP_W-1:0]    op_q;
	logic               phase_q;
	logic [AW-1:0]      b_q;
	logic [AW-1:0]      start_q;
	logic [AW-1:0]      cur_q;
	logic [AW-1:0]      root_q;
	logic [AW-1:0]      ra_q;
	logic [AW-1:0]      rb_q;
	logic [SW-1:0]      sa_q;
	uf_result_t         res_q;

	// memories
	logic [AW-1:0] par_mem  [DEPTH];
	logic [SW-1:0] size_mem [DEPTH];
	logic [AW-1:0] par_rd_q;
	logic [SW-1:0] size_rd_q;

	logic          par_we;
	logic [AW-1:0] par_waddr;
	logic [AW-1:0] par_wdata;
	logic [AW-1:0] par_raddr;
	logic          size_we;
	logic [AW-1:0] size_waddr;
	logic [SW-1:0] size_wdata;
	logic [AW-1:0] size_raddr;

	logic          find_done;
	logic [AW-1:0] find_root;
	logic [AW-1:0] big;
	logic [AW-1:0] small_root;
	logic [SW-1:0] size_sum;
	logic          in_err;
	logic [COUNT_W-1:0] comp_dec;

	assign sweep_end = (count_q > COUNT_W'(DEPTH)) ? (AW+1)'(DEPTH) : count_q[AW:0];
	assign cfg_sat   = (cfg_data > COUNT_W'(CAP)) ? COUNT_W'(CAP) : cfg_data;
	assign comp_dec  = (comp_q != '0) ? comp_q - COUNT_W'(1) : comp_q;

	assign in_err = ({1'b0, req.first_element} >= count_q) ||
		(needs_second(req.operation) && ({1'b0, req.second_element} >= count_q));

	// merge: smaller set goes under larger, ties keep the first root
	assign big        = (sa_q < size_rd_q) ? rb_q : ra_q;
	assign small_root = (sa_q < size_rd_q) ? ra_q : rb_q;
	assign size_sum   = sa_q + size_rd_q;

	assign req.ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	// memory ports
	always_comb begin
		par_we     = 1'b0;
		par_waddr  = '0;
		par_wdata  = '0;
		par_raddr  = '0;
		size_we    = 1'b0;
		size_waddr = '0;
		size_wdata = '0;
		size_raddr = '0;
		find_done  = 1'b0;
		find_root  = cur_q;
		case (state_q)
			ST_INIT: begin
				if (sweep_q < sweep_end) begin
					par_we     = 1'b1;
					par_waddr  = sweep_q[AW-1:0];
					par_wdata  = sweep_q[AW-1:0];
					size_we    = 1'b1;
					size_waddr = sweep_q[AW-1:0];
					size_wdata = SW'(1);
				end
			end
			ST_IDLE: begin
				par_raddr = req.first_element[AW-1:0];
			end
			ST_WALK: begin
				if (par_rd_q == cur_q) begin
					if (start_q == cur_q) begin
						find_done = 1'b1;
						find_root = cur_q;
					end else begin
						par_raddr = start_q;
					end
				end else begin
					par_raddr = par_rd_q;
				end
			end
			ST_COMP: begin
				par_we    = 1'b1;
				par_waddr = cur_q;
				par_wdata = root_q;
				if (par_rd_q == root_q) begin
					find_done = 1'b1;
					find_root = root_q;
				end else begin
					par_raddr = par_rd_q;
				end
			end
			ST_SZ1: begin
				size_raddr = rb_q;
			end
			ST_SZ2: begin
				size_we    = 1'b1;
				size_waddr = big;
				size_wdata = size_sum;
				par_we     = 1'b1;
				par_waddr  = small_root;
				par_wdata  = big;
			end
			default: begin
			end
		endcase
		// next find or size lookup once a root is known
		if (find_done) begin
			if (!phase_q && needs_second(op_q)) begin
				par_raddr = b_q;
			end else begin
				size_raddr = phase_q ? ra_q : find_root;
			end
		end
	end

	// read-modify-write memories, same-cycle write forwarded to the read
	always_ff @(posedge clk) begin
		if (par_we) begin
			par_mem[par_waddr] <= par_wdata;
		end
		if (size_we) begin
			size_mem[size_waddr] <= size_wdata;
		end
		par_rd_q  <= (par_we && par_waddr == par_raddr) ? par_wdata : par_mem[par_raddr];
		size_rd_q <= (size_we && size_waddr == size_raddr) ? size_wdata
			: size_mem[size_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			sweep_q <= '0;
			count_q <= COUNT_W'(RST_COUNT);
			comp_q  <= COUNT_W'(RST_COUNT);
			phase_q <= 1'b0;
		end else if (cfg_we) begin
			count_q <= cfg_sat;
			comp_q  <= cfg_sat;
			sweep_q <= '0;
			state_q <= ST_INIT;
		end else begin
			case (state_q)
				ST_INIT: begin
					if (sweep_q < sweep_end) begin
						sweep_q <= sweep_q + (AW+1)'(1);
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						op_q <= req.operation;
						if (in_err) begin
							res_q.root        <= '0;
							res_q.flag        <= 1'b0;
							res_q.set_size    <= '0;
							res_q.components  <= comp_q;
							res_q.index_error <= 1'b1;
							state_q           <= ST_DONE;
						end else begin
							cur_q   <= req.first_element[AW-1:0];
							start_q <= req.first_element[AW-1:0];
							b_q     <= req.second_element[AW-1:0];
							phase_q <= 1'b0;
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (par_rd_q == cur_q) begin
						root_q <= cur_q;
						if (start_q != cur_q) begin
							cur_q   <= start_q;
							state_q <= ST_COMP;
						end
					end else begin
						cur_q <= par_rd_q;
					end
				end
				ST_COMP: begin
					if (par_rd_q != root_q) begin
						cur_q <= par_rd_q;
					end
				end
				ST_SZ1: begin
					if (op_q == OP_MERGE && ra_q != rb_q) begin
						sa_q    <= size_rd_q;
						state_q <= ST_SZ2;
					end else begin
						res_q.root        <= ELEM_W'(ra_q);
						res_q.flag        <= (op_q == OP_SAME) && (ra_q == rb_q);
						res_q.set_size    <= COUNT_W'(size_rd_q);
						res_q.components  <= comp_q;
						res_q.index_error <= 1'b0;
						state_q           <= ST_DONE;
					end
				end
				ST_SZ2: begin
					res_q.root        <= ELEM_W'(big);
					res_q.flag        <= 1'b1;
					res_q.set_size    <= COUNT_W'(size_sum);
					res_q.components  <= comp_dec;
					res_q.index_error <= 1'b0;
					comp_q            <= comp_dec;
					state_q           <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (find_done) begin
				if (!phase_q) begin
					ra_q <= find_root;
					if (needs_second(op_q)) begin
						phase_q <= 1'b1;
						cur_q   <= b_q;
						start_q <= b_q;
						state_q <= ST_WALK;
					end else begin
						state_q <= ST_SZ1;
					end
				end else begin
					rb_q    <= find_root;
					state_q <= ST_SZ1;
				end
			end
		end
	end

endmodule

/* hdl/uf_out_reg.sv */
// ----------------------------------------------------------------------------
// uf_out_reg
// Result register between the core and the response channel.
// ----------------------------------------------------------------------------
module uf_out_reg import uf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  uf_result_t res,
	input  logic       res_valid,
	output logic       res_ready,
	uf_rsp_if.source   rsp
);

	logic       valid_q;
	uf_result_t data_q;

	assign res_ready = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			data_q <= res;
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.root        = data_q.root;
	assign rsp.flag        = data_q.flag;
	assign rsp.set_size    = data_q.set_size;
	assign rsp.components  = data_q.components;
	assign rsp.index_error = data_q.index_error;

endmodule

/* hdl/union_find_engine.sv */
// ----------------------------------------------------------------------------
// union_find_engine
// Disjoint-set table with union by size and path compression over the
// first element_count entries.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          carries
//  -------   ---------  ---------          -------
//  req       in         valid/ready        operation, first_element, second_element
//  rsp       out        valid/ready        root, flag, set_size, components, index_error
//  cfg       in         cfg_we, no stall   element_count (cfg_data)
//
//  One transaction at a time. A find reads parent entries up to the root,
//  then walks the chain again and writes the root into each entry on it
//  (path compression). Same-set and merge run a second find. Each
//  operation reads the size of the first root; a joining merge also reads
//  the second and writes the new size and parent. An index error is
//  answered without a walk. Union by size bounds the chain depth by
//  log2(element_count) and compression keeps it near 1.
//  After reset and after each element_count write an init sweep writes one
//  entry per cycle over the first min(element_count, table depth) entries,
//  then returns to idle; req.ready stays low meanwhile. A result waiting on
//  rsp does not stall the next request; only a second finished result
//  waits for the output register.
// ----------------------------------------------------------------------------
module union_find_engine import uf_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_data,
	uf_req_if.sink             req,
	uf_rsp_if.source           rsp
);

	uf_result_t res;        // finished result from the core
	logic       res_valid;
	logic       res_ready;  // output register free or draining

	// sequencer and tables
	uf_core #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.req       (req),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

	// decouples the core from a stalled consumer
	uf_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.rsp       (rsp)
	);

endmodule
